// ===== rtl/qlt_pkg.sv =====
// Package with the shared types and character codes of the quoted line tokenizer.
`default_nettype none

package qlt_pkg;

    // Character codes the scanner reacts to
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_HASH   = 8'h23;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;

    // Most results that one input byte can cause
    localparam int MAX_RESULTS = 3;

    // Scanner mode
    typedef enum logic [1:0] {
        MODE_OUTSIDE = 2'd0,
        MODE_SINGLE  = 2'd1,
        MODE_DOUBLE  = 2'd2,
        MODE_COMMENT = 2'd3
    } mode_t;

    // Kind of a result
    typedef enum logic [2:0] {
        KIND_TOKEN_BYTE   = 3'd0,
        KIND_TOKEN_END    = 3'd1,
        KIND_COMMENT_BYTE = 3'd2,
        KIND_LINE_OK      = 3'd3,
        KIND_UNCLOSED     = 3'd4
    } kind_t;

    // One result
    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
    } result_t;

    // Everything the decoder hands to the result stage
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   res;
        mode_t                       mode;
        logic                        tok_open;
    } decode_t;

endpackage

`default_nettype wire

// ===== rtl/qlt_decode.sv =====
// Combinational decoder: one byte and the scanner state in, up to three results out.
`default_nettype none

module qlt_decode (
    input  wire logic [7:0]     in_byte,
    input  wire logic           end_of_line,
    input  wire qlt_pkg::mode_t mode,
    input  wire logic           tok_open,
    output qlt_pkg::decode_t    dec
);
    import qlt_pkg::*;

    always_comb
    begin
        dec          = '0;
        dec.mode     = mode;
        dec.tok_open = tok_open;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            dec.res[i].kind = KIND_TOKEN_BYTE;
        end

        if (end_of_line)
        begin
            // End of line: unclosed quote, or close any token and report success.
            if (mode == MODE_SINGLE || mode == MODE_DOUBLE)
            begin
                dec.res[0].kind = KIND_UNCLOSED;
                dec.count       = 2'd1;
            end
            else if (tok_open)
            begin
                dec.res[0].kind = KIND_TOKEN_END;
                dec.res[1].kind = KIND_LINE_OK;
                dec.count       = 2'd2;
            end
            else
            begin
                dec.res[0].kind = KIND_LINE_OK;
                dec.count       = 2'd1;
            end
            dec.mode     = MODE_OUTSIDE;
            dec.tok_open = 1'b0;
        end
        else if (mode == MODE_COMMENT)
        begin
            // Everything after the hash is comment text.
            dec.res[0].data = in_byte;
            dec.res[0].kind = KIND_COMMENT_BYTE;
            dec.count       = 2'd1;
        end
        else if (mode == MODE_SINGLE || mode == MODE_DOUBLE)
        begin
            // Inside quotes only the matching quote is special.
            if ((mode == MODE_SINGLE && in_byte == CHAR_SQUOTE) ||
                (mode == MODE_DOUBLE && in_byte == CHAR_DQUOTE))
            begin
                dec.res[0].kind = KIND_TOKEN_END;
                dec.count       = 2'd1;
                dec.tok_open    = 1'b0;
                dec.mode        = MODE_OUTSIDE;
            end
            else
            begin
                dec.res[0].data = in_byte;
                dec.res[0].kind = KIND_TOKEN_BYTE;
                dec.count       = 2'd1;
                dec.tok_open    = 1'b1;
            end
        end
        else
        begin
            // Outside quotes: separators, quotes and the comment mark.
            case (in_byte)
                CHAR_SQUOTE, CHAR_DQUOTE:
                begin
                    if (tok_open)
                    begin
                        dec.res[0].kind = KIND_TOKEN_END;
                        dec.count       = 2'd1;
                    end
                    dec.tok_open = 1'b1;
                    dec.mode     = (in_byte == CHAR_SQUOTE) ? MODE_SINGLE : MODE_DOUBLE;
                end
                CHAR_HASH:
                begin
                    if (tok_open)
                    begin
                        dec.res[0].kind = KIND_TOKEN_END;
                        dec.count       = 2'd1;
                    end
                    dec.tok_open = 1'b0;
                    dec.mode     = MODE_COMMENT;
                end
                CHAR_EQUALS, CHAR_COMMA:
                begin
                    if (tok_open)
                    begin
                        dec.res[0].kind = KIND_TOKEN_END;
                        dec.res[1].data = in_byte;
                        dec.res[1].kind = KIND_TOKEN_BYTE;
                        dec.res[2].kind = KIND_TOKEN_END;
                        dec.count       = 2'd3;
                    end
                    else
                    begin
                        dec.res[0].data = in_byte;
                        dec.res[0].kind = KIND_TOKEN_BYTE;
                        dec.res[1].kind = KIND_TOKEN_END;
                        dec.count       = 2'd2;
                    end
                    dec.tok_open = 1'b0;
                end
                default:
                begin
                    if (in_byte <= CHAR_SPACE)
                    begin
                        if (tok_open)
                        begin
                            dec.res[0].kind = KIND_TOKEN_END;
                            dec.count       = 2'd1;
                        end
                        dec.tok_open = 1'b0;
                    end
                    else
                    begin
                        dec.res[0].data = in_byte;
                        dec.res[0].kind = KIND_TOKEN_BYTE;
                        dec.count       = 2'd1;
                        dec.tok_open    = 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/quoted_line_tokenizer_unit.sv =====
// Top level of the quoted line tokenizer: input register, decoder and result queue.
//
// Usage: characters of a line arrive one per request on the s_axis channel, the
// byte in tdata; a request with tlast high marks the end of the line and its
// tdata is ignored. Results leave on m_axis: tdata carries the byte, tuser the
// kind (token byte, end of token, comment byte, line ok, unclosed quote) and
// tlast flags the final result caused by one input request.
// A request accepted on s_axis is held in the input register, then decoded and
// loaded into the result queue as soon as the queue can take it; its first
// result is then valid on m_axis. Throughput: one request per cycle while each
// causes at most one result and the receiver is ready. A request that causes
// two or three results holds the next request in the input register until the
// single output port takes the last of them from the three-entry result queue;
// a request that causes no result does not hold the next one.
// When the receiver stalls, the queue and then the input register fill and
// s_axis_tready falls; nothing is lost. Reset empties both stages and returns
// the scanner to outside-quotes with no token open.
`default_nettype none

module quoted_line_tokenizer_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // end_of_line
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic [2:0]      m_axis_tuser,   // [2:0] out_kind
    output logic            m_axis_tlast    // last
);
    import qlt_pkg::*;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eol_reg;

    // Scanner state
    mode_t mode_reg;
    logic  open_reg;

    // Result queue, head at entry zero
    result_t [MAX_RESULTS-1:0] slot_reg;
    logic    [MAX_RESULTS-1:0] slot_last_reg;
    logic    [1:0]             count_reg;

    decode_t dec;
    logic    out_take;
    logic    load;
    logic    advance;

    qlt_decode u_decode (
        .in_byte     (in_byte_reg),
        .end_of_line (in_eol_reg),
        .mode        (mode_reg),
        .tok_open    (open_reg),
        .dec         (dec)
    );

    // The queue takes a decoded request once it will be empty after this cycle.
    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign load          = (count_reg == 2'd0) || (count_reg == 2'd1 && m_axis_tready);
    assign advance       = in_valid_reg && load;
    assign s_axis_tready = !in_valid_reg || load;

    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tdata  = slot_reg[0].data;
    assign m_axis_tuser  = slot_reg[0].kind;
    assign m_axis_tlast  = slot_last_reg[0];

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eol_reg  <= s_axis_tlast;
        end
    end

    // Scanner state and queue fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OUTSIDE;
            open_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else if (advance)
        begin
            mode_reg  <= dec.mode;
            open_reg  <= dec.tok_open;
            count_reg <= dec.count;
        end
        else if (load)
        begin
            count_reg <= 2'd0;
        end
        else if (out_take)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    // Queue payload: load a new group or shift towards the head
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < MAX_RESULTS; i++)
            begin
                slot_reg[i]      <= dec.res[i];
                slot_last_reg[i] <= (dec.count == 2'(i + 1));
            end
        end
        else if (out_take)
        begin
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                slot_reg[i]      <= slot_reg[i + 1];
                slot_last_reg[i] <= slot_last_reg[i + 1];
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Only the final entry of a group may carry the last flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg > 2'd1) |-> !slot_last_reg[0])
        else $error("last flag set ahead of the final result");

    // A line status result always closes its group.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tuser == KIND_LINE_OK || m_axis_tuser == KIND_UNCLOSED))
        |-> m_axis_tlast)
        else $error("line status result without last flag");

    // After an end of line the scanner is back outside quotes with no token.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_eol_reg) |=> (mode_reg == MODE_OUTSIDE && !open_reg))
        else $error("scanner state not cleared at end of line");

    // Results without a character carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_TOKEN_BYTE &&
         m_axis_tuser != KIND_COMMENT_BYTE) |-> (m_axis_tdata == 8'd0))
        else $error("non-character result carries a byte");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/quoted_line_tokenizer_unit_tb.sv =====
// Self-checking testbench for the quoted line tokenizer: line stimulus, token prediction, checks.
`timescale 1ns / 1ps

module quoted_line_tokenizer_unit_tb;

    import qlt_pkg::*;

    // Cycles in which no request is accepted and no result taken before the run is abandoned
    localparam int unsigned STALL_LIMIT = 2000;
    // Cycles allowed after the last expected result for stray output
    localparam int unsigned TAIL_CYCLES = 12;

    // One expected result of the tokenizer
    typedef struct {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } token_result_t;

    // Tracks the scanner state and holds the results still awaited on the output
    class token_scoreboard;
        mode_t         scan_mode;
        logic          token_open;
        token_result_t step_results[$];
        token_result_t awaited_tokens[$];
        int unsigned   mismatch_count;

        function new();
            scan_mode      = MODE_OUTSIDE;
            token_open     = 1'b0;
            mismatch_count = 0;
        endfunction

        function int awaited_count();
            return awaited_tokens.size();
        endfunction

        function void push_result(logic [7:0] data, kind_t kind);
            token_result_t r;
            r.data = data;
            r.kind = kind;
            r.last = 1'b0;
            step_results.insert(step_results.size(), r);
        endfunction

        // Closes a pending token, if there is one
        function void end_token();
            if (token_open)
            begin
                push_result(8'h00, KIND_TOKEN_END);
                token_open = 1'b0;
            end
        endfunction

        // Works out the results of one accepted input request
        function void note_request(logic [7:0] c, logic eol);
            logic [7:0] closer;
            step_results.delete();
            if (eol)
            begin
                if (scan_mode == MODE_SINGLE || scan_mode == MODE_DOUBLE)
                begin
                    push_result(8'h00, KIND_UNCLOSED);
                end
                else
                begin
                    end_token();
                    push_result(8'h00, KIND_LINE_OK);
                end
                scan_mode  = MODE_OUTSIDE;
                token_open = 1'b0;
            end
            else if (scan_mode == MODE_COMMENT)
            begin
                push_result(c, KIND_COMMENT_BYTE);
            end
            else if (scan_mode == MODE_SINGLE || scan_mode == MODE_DOUBLE)
            begin
                // Inside quotes only the matching quote is special
                if (scan_mode == MODE_SINGLE)
                    closer = CHAR_SQUOTE;
                else
                    closer = CHAR_DQUOTE;
                if (c == closer)
                begin
                    push_result(8'h00, KIND_TOKEN_END);
                    token_open = 1'b0;
                    scan_mode  = MODE_OUTSIDE;
                end
                else
                begin
                    push_result(c, KIND_TOKEN_BYTE);
                    token_open = 1'b1;
                end
            end
            else if (c == CHAR_SQUOTE || c == CHAR_DQUOTE)
            begin
                end_token();
                token_open = 1'b1;
                if (c == CHAR_SQUOTE)
                    scan_mode = MODE_SINGLE;
                else
                    scan_mode = MODE_DOUBLE;
            end
            else if (c == CHAR_HASH)
            begin
                end_token();
                scan_mode = MODE_COMMENT;
            end
            else if (c == CHAR_EQUALS || c == CHAR_COMMA)
            begin
                end_token();
                push_result(c, KIND_TOKEN_BYTE);
                push_result(8'h00, KIND_TOKEN_END);
            end
            else if (c <= CHAR_SPACE)
            begin
                end_token();
            end
            else
            begin
                push_result(c, KIND_TOKEN_BYTE);
                token_open = 1'b1;
            end

            if (step_results.size() > 0)
                step_results[step_results.size() - 1].last = 1'b1;
            foreach (step_results[i])
                awaited_tokens.insert(awaited_tokens.size(), step_results[i]);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatch_count++;
        endtask

        // Compares one accepted result with the oldest awaited one
        task check_result(logic [7:0] data, logic [2:0] kind, logic last);
            token_result_t want;
            if (awaited_tokens.size() == 0)
            begin
                report($sformatf("unexpected result data %02h kind %0d last %0b",
                                 data, kind, last));
                return;
            end
            want = awaited_tokens.pop_front();
            if (data !== want.data)
                report($sformatf("data %02h, expected %02h", data, want.data));
            if (kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (last !== want.last)
                report($sformatf("last %0b, expected %0b", last, want.last));
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       m_axis_tlast;

    token_scoreboard sb = new();

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned requests_sent      = 0;
    int unsigned quiet_cycles       = 0;

    quoted_line_tokenizer_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

    // Monitor: results are checked before the request of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_request(s_axis_tdata, s_axis_tlast);
        end
    end

    // Watchdog on cycles in which no request is accepted and no result is taken
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Offers one request, with random idle cycles first, and waits for acceptance
    task automatic send_request(logic [7:0] b, logic eol);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eol;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        requests_sent++;
    endtask

    // Holds the sender back until every awaited result has arrived
    task automatic wait_until_drained();
        s_axis_tvalid <= 1'b0;
        // This wait lets the monitor note the final accepted request first
        @(posedge clk);
        while (sb.awaited_count() != 0)
            @(posedge clk);
    endtask

    // A byte above the blank with no special meaning outside quotes
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(8'h21, 8'hFF));
        while (b inside {CHAR_SQUOTE, CHAR_DQUOTE, CHAR_HASH, CHAR_EQUALS, CHAR_COMMA});
        return b;
    endfunction

    // One line made of tokens, blanks, separators, quoted text and comments
    task automatic send_random_line();
        int         pieces;
        int         run;
        logic [7:0] quote_char;
        logic [7:0] b;
        bit         line_done;
        pieces    = $urandom_range(1, 8);
        line_done = 1'b0;
        for (int p = 0; p < pieces && !line_done; p++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    run = $urandom_range(1, 4);
                    repeat (run) send_request(plain_byte(), 1'b0);
                end
                4: send_request(8'($urandom_range(0, 32)), 1'b0);
                5: send_request(($urandom_range(0, 1) != 0) ? CHAR_EQUALS : CHAR_COMMA, 1'b0);
                6, 7:
                begin
                    quote_char = ($urandom_range(0, 1) != 0) ? CHAR_SQUOTE : CHAR_DQUOTE;
                    send_request(quote_char, 1'b0);
                    run = $urandom_range(0, 4);
                    repeat (run)
                    begin
                        // The equals sign and the blank turn up often inside quotes
                        if ($urandom_range(0, 3) == 0)
                            b = ($urandom_range(0, 1) != 0) ? CHAR_EQUALS : CHAR_SPACE;
                        else
                            b = 8'($urandom_range(0, 255));
                        if (b == quote_char)
                            b = CHAR_HASH;
                        send_request(b, 1'b0);
                    end
                    // Now and then the closing quote is left out
                    if ($urandom_range(0, 9) == 0)
                        line_done = 1'b1;
                    else
                        send_request(quote_char, 1'b0);
                end
                8: send_request(8'($urandom_range(0, 255)), 1'b0);
                default:
                begin
                    send_request(CHAR_HASH, 1'b0);
                    run = $urandom_range(0, 4);
                    repeat (run) send_request(8'($urandom_range(0, 255)), 1'b0);
                    line_done = 1'b1;
                end
            endcase
        end
        send_request(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Directed lines: {end_of_line, byte}
    logic [8:0] directed_stream [] = '{
        9'h0FF, 9'h000, {1'b0, 8'h61}, {1'b0, CHAR_EQUALS}, {1'b0, CHAR_COMMA},
        {1'b0, 8'h62}, {1'b0, CHAR_SQUOTE}, {1'b0, CHAR_EQUALS}, {1'b0, CHAR_DQUOTE},
        {1'b0, CHAR_HASH}, {1'b0, CHAR_COMMA}, {1'b0, CHAR_SPACE}, {1'b0, CHAR_SQUOTE},
        {1'b0, CHAR_DQUOTE}, {1'b0, CHAR_DQUOTE}, {1'b0, 8'h63}, {1'b0, CHAR_HASH},
        {1'b0, CHAR_SQUOTE}, 9'h0FF, 9'h1FF,
        {1'b0, CHAR_DQUOTE}, {1'b0, 8'h71}, 9'h100,
        9'h1AA,
        {1'b0, 8'h7A}, 9'h155
    };

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idling phases: none, sender only, receiver only, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 55;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 55;
                end
                default:
                begin
                    sender_idle_pct    = 34;
                    receiver_stall_pct = 34;
                end
            endcase
            if (phase == 0)
            begin
                foreach (directed_stream[i])
                    send_request(directed_stream[i][7:0], directed_stream[i][8]);
            end
            while (requests_sent < (phase + 1) * 55)
                send_random_line();
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        // Results that never arrived count against the run
        if (sb.awaited_count() != 0)
            sb.report($sformatf("%0d results never arrived", sb.awaited_count()));

        if (sb.mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
